@@ sv/mai_pkg.sv @@
package mai_pkg;

    typedef enum logic [2:0] {
        FN_ASSIGN = 3'd0,
        FN_ADD    = 3'd1,
        FN_MULW   = 3'd2,
        FN_MULP5  = 3'd3,
        FN_SHL    = 3'd4,
        FN_APPEND = 3'd5,
        FN_READ   = 3'd6
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [63:0] operand;
        logic [11:0] amount;
        logic [5:0]  word_index;
    } mai_cmd_t;

    typedef struct packed {
        logic [63:0] word_value;
        logic [6:0]  word_count;
        logic        is_zero;
        logic        overflow;
    } mai_res_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_NEXT,
        S_MUL_RD,
        S_MUL_LD,
        S_MUL_X,
        S_MUL_WR,
        S_ADD_RD,
        S_ADD_WR,
        S_PUSH,
        S_SH_RD,
        S_SH_WR,
        S_SH_END,
        S_TRIM,
        S_TRIM_CHK,
        S_READ,
        S_READ_D,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_POW,
        PH_SHIFT,
        PH_FINAL
    } phase_t;

    localparam logic [63:0] POW5_27 = 64'h6765C793FA10079D;
    localparam logic [63:0] POW5_13 = 64'd1220703125;
    localparam logic [11:0] EXP_BIG = 12'd27;
    localparam logic [11:0] EXP_MID = 12'd13;

    function automatic logic [63:0] pow5_small(input logic [3:0] k);
        logic [63:0] r;
        case (k)
            4'd0:    r = 64'd5;
            4'd1:    r = 64'd25;
            4'd2:    r = 64'd125;
            4'd3:    r = 64'd625;
            4'd4:    r = 64'd3125;
            4'd5:    r = 64'd15625;
            4'd6:    r = 64'd78125;
            4'd7:    r = 64'd390625;
            4'd8:    r = 64'd1953125;
            4'd9:    r = 64'd9765625;
            4'd10:   r = 64'd48828125;
            4'd11:   r = 64'd244140625;
            default: r = 64'd5;
        endcase
        return r;
    endfunction

endpackage

@@ sv/mai_ram.sv @@
module mai_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         q
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q <= mem[raddr];
    end

endmodule

@@ sv/multiword_integer_accumulator_core.sv @@
// Multiword unsigned accumulator, up to WORDS 64-bit words, lowest word first.
// Command channel (cmd_valid/cmd_ready, payload cmd) takes one item when the
// sequencer is idle; the response channel (res_valid/res_ready, payload res)
// returns exactly one result per item from an output register, so the next
// item is taken while a result still waits.
// The states run depend on the function and on the words in use (U):
//   assign, unused code: straight from dispatch to the done state;
//   read: one registered RAM read, skipped when the index is out of range.
//   add: a read and a write per word rippled, plus push and trim.
//   multiply by word: word by word through one shared 32x32 multiplier
//   (four partial products into a 128-bit accumulator), plus push and trim.
//   multiply by 5^n: one multiply pass per factor (27, 13, remainder).
//   shift left by n: a read and a write per word over U + n/64 + 1 words, plus trim.
//   append chunk: power-of-five passes, then shift, then add.
//   Trim checks and drops high zero words one at a time.
// Word storage is one RAM with one write and one registered read port; word 0
// is also held in a register, so reset needs no clearing pass: after reset the
// value is a single zero word. A stalled receiver holds the result; a finished
// item then waits in the done state until the output register frees.
module multiword_integer_accumulator_core
    import mai_pkg::*;
#(
    parameter int WORDS = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  mai_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_ready,
    output mai_res_t res
);

    localparam int AW = $clog2(WORDS);
    localparam int CW = $clog2(WORDS + 1);
    localparam int IW = CW + 7;

    state_t       state_reg, state_next;
    phase_t       phase_reg, phase_next;
    mai_cmd_t     cmd_reg, cmd_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] nold_reg, nold_next;
    logic [63:0]  word0_reg, word0_next;
    logic [IW-1:0] i_reg, i_next;
    logic [11:0]  e_reg, e_next;
    logic [63:0]  m_reg, m_next;
    logic [63:0]  a_reg, a_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  prod_reg, prod_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [63:0]  carry_reg, carry_next;
    logic [63:0]  hi_reg, hi_next;
    logic         ovf_reg, ovf_next;
    logic [63:0]  rv_reg, rv_next;
    logic         rd0_reg;
    mai_res_t     res_reg, res_next;
    logic         res_valid_reg, res_valid_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, ram_q, rdword;

    logic [IW-1:0] used_x, nold_x, off_x, idx_x, top1, src_m1;
    logic [5:0]    bits;
    logic          is_zero_now, mul_last, add_go, sh_src_ok, sh_in_range, out_free;
    logic          mul_start, sh_skip;
    logic [63:0]   sh_lo, sh_w, aa_w, bb_w;
    logic [31:0]   aa, bb;
    logic [127:0]  addend;
    logic [64:0]   sum65;
    logic [11:0]   em1;

    mai_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .q     (ram_q)
    );

    assign used_x      = IW'(used_reg);
    assign nold_x      = IW'(nold_reg);
    assign off_x       = IW'(cmd_reg.amount[11:6]);
    assign idx_x       = IW'(cmd_reg.word_index);
    assign bits        = cmd_reg.amount[5:0];
    assign top1        = nold_x + off_x + IW'(1);
    assign src_m1      = i_reg - off_x - IW'(1);
    assign is_zero_now = (used_reg == CW'(1)) && (word0_reg == 64'd0);
    assign rdword      = rd0_reg ? word0_reg : ram_q;
    assign mul_last    = (i_reg + IW'(1)) == used_x;
    assign add_go      = (i_reg < used_x) && (carry_reg != 64'd0);
    assign sh_src_ok   = (i_reg > off_x) && (src_m1 < nold_x);
    assign sh_in_range = i_reg < IW'(WORDS);
    assign sh_lo       = sh_src_ok ? rdword : 64'd0;
    assign sh_w        = (bits == 6'd0) ? hi_reg
                       : ((hi_reg << bits) | (sh_lo >> (7'd64 - {1'b0, bits})));
    assign sh_skip     = (cmd_reg.amount == 12'd0) || is_zero_now;
    assign out_free    = !res_valid_reg || res_ready;
    assign em1         = e_reg - 12'd1;
    assign aa_w        = a_reg;
    assign bb_w        = m_reg;
    assign aa          = cnt_reg[1] ? aa_w[63:32] : aa_w[31:0];
    assign bb          = cnt_reg[0] ? bb_w[63:32] : bb_w[31:0];
    assign sum65       = {1'b0, rdword} + {1'b0, carry_reg};
    assign mul_start   = (state_reg == S_NEXT) && (phase_reg == PH_POW)
                         && (e_reg != 12'd0);

    always_comb
    begin
        case (cnt_reg)
            3'd1:    addend = {64'd0, prod_reg};
            3'd2:    addend = {32'd0, prod_reg, 32'd0};
            3'd3:    addend = {32'd0, prod_reg, 32'd0};
            3'd4:    addend = {prod_reg, 64'd0};
            default: addend = 128'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg.func)
                    FN_ADD:    state_next = S_ADD_RD;
                    FN_MULW:   state_next = (cmd_reg.operand == 64'd0) ? S_DONE : S_MUL_RD;
                    FN_MULP5:  state_next = S_NEXT;
                    FN_SHL:    state_next = sh_skip ? S_NEXT : S_SH_RD;
                    FN_APPEND: state_next = is_zero_now ? S_DONE : S_NEXT;
                    FN_READ:   state_next = S_READ;
                    default:   state_next = S_DONE;
                endcase
            end
            S_NEXT:
            begin
                case (phase_reg)
                    PH_POW:
                    begin
                        if (e_reg != 12'd0)
                        begin
                            state_next = S_MUL_RD;
                        end
                        else if (cmd_reg.func == FN_APPEND)
                        begin
                            state_next = sh_skip ? S_NEXT : S_SH_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    PH_SHIFT:
                    begin
                        state_next = (cmd_reg.func == FN_APPEND) ? S_ADD_RD : S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_MUL_RD: state_next = S_MUL_LD;
            S_MUL_LD: state_next = S_MUL_X;
            S_MUL_X:  state_next = (cnt_reg == 3'd4) ? S_MUL_WR : S_MUL_X;
            S_MUL_WR:
            begin
                if (mul_last)
                begin
                    state_next = (acc_reg[127:64] != 64'd0) ? S_PUSH : S_TRIM;
                end
                else
                begin
                    state_next = S_MUL_RD;
                end
            end
            S_ADD_RD:
            begin
                if (add_go)
                begin
                    state_next = S_ADD_WR;
                end
                else
                begin
                    state_next = (carry_reg != 64'd0) ? S_PUSH : S_TRIM;
                end
            end
            S_ADD_WR: state_next = S_ADD_RD;
            S_PUSH:   state_next = S_TRIM;
            S_SH_RD:  state_next = S_SH_WR;
            S_SH_WR:  state_next = (i_reg == IW'(0)) ? S_SH_END : S_SH_RD;
            S_SH_END: state_next = S_TRIM;
            S_TRIM:   state_next = (used_reg > CW'(1)) ? S_TRIM_CHK : S_NEXT;
            S_TRIM_CHK: state_next = (rdword == 64'd0) ? S_TRIM : S_NEXT;
            S_READ:   state_next = (idx_x < used_x) ? S_READ_D : S_DONE;
            S_READ_D: state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        cmd_next       = cmd_reg;
        used_next      = used_reg;
        nold_next      = nold_reg;
        word0_next     = word0_reg;
        i_next         = i_reg;
        e_next         = e_reg;
        m_next         = m_reg;
        a_next         = a_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        carry_next     = carry_reg;
        hi_next        = hi_reg;
        ovf_next       = ovf_reg;
        rv_next        = rv_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        we             = 1'b0;
        waddr          = i_reg[AW-1:0];
        wdata          = acc_reg[63:0];
        raddr          = i_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                cmd_next = cmd;
                ovf_next = 1'b0;
            end
            S_DISPATCH:
            begin
                i_next     = IW'(0);
                carry_next = cmd_reg.operand;
                e_next     = cmd_reg.amount;
                m_next     = cmd_reg.operand;
                hi_next    = 64'd0;
                nold_next  = used_reg;
                i_next     = (cmd_reg.func == FN_SHL) ? (used_x + off_x) : IW'(0);
                case (cmd_reg.func)
                    FN_ASSIGN:
                    begin
                        word0_next = cmd_reg.operand;
                        used_next  = CW'(1);
                    end
                    FN_ADD:    phase_next = PH_FINAL;
                    FN_MULW:
                    begin
                        phase_next = PH_FINAL;
                        carry_next = 64'd0;
                        if (cmd_reg.operand == 64'd0)
                        begin
                            word0_next = 64'd0;
                            used_next  = CW'(1);
                        end
                    end
                    FN_MULP5:  phase_next = PH_POW;
                    FN_SHL:    phase_next = PH_SHIFT;
                    FN_APPEND:
                    begin
                        phase_next = PH_POW;
                        if (is_zero_now)
                        begin
                            word0_next = cmd_reg.operand;
                            used_next  = CW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            S_NEXT:
            begin
                case (phase_reg)
                    PH_POW:
                    begin
                        if (mul_start)
                        begin
                            i_next     = IW'(0);
                            carry_next = 64'd0;
                            if (e_reg >= EXP_BIG)
                            begin
                                m_next = POW5_27;
                                e_next = e_reg - EXP_BIG;
                            end
                            else if (e_reg >= EXP_MID)
                            begin
                                m_next = POW5_13;
                                e_next = e_reg - EXP_MID;
                            end
                            else
                            begin
                                m_next = pow5_small(em1[3:0]);
                                e_next = 12'd0;
                            end
                        end
                        else if (cmd_reg.func == FN_APPEND)
                        begin
                            phase_next = PH_SHIFT;
                            hi_next    = 64'd0;
                            nold_next  = used_reg;
                            i_next     = used_x + off_x;
                        end
                    end
                    PH_SHIFT:
                    begin
                        phase_next = PH_FINAL;
                        carry_next = cmd_reg.operand;
                        i_next     = IW'(0);
                    end
                    default: ;
                endcase
            end
            S_MUL_LD:
            begin
                a_next   = rdword;
                acc_next = {64'd0, carry_reg};
                cnt_next = 3'd0;
            end
            S_MUL_X:
            begin
                prod_next = {32'd0, aa} * {32'd0, bb};
                acc_next  = acc_reg + addend;
                cnt_next  = cnt_reg + 3'd1;
            end
            S_MUL_WR:
            begin
                we         = 1'b1;
                wdata      = acc_reg[63:0];
                carry_next = acc_reg[127:64];
                i_next     = i_reg + IW'(1);
                if (i_reg == IW'(0))
                begin
                    word0_next = acc_reg[63:0];
                end
            end
            S_ADD_WR:
            begin
                we         = 1'b1;
                wdata      = sum65[63:0];
                carry_next = {63'd0, sum65[64]};
                i_next     = i_reg + IW'(1);
                if (i_reg == IW'(0))
                begin
                    word0_next = sum65[63:0];
                end
            end
            S_PUSH:
            begin
                waddr = used_reg[AW-1:0];
                wdata = carry_reg;
                if (used_x < IW'(WORDS))
                begin
                    we        = 1'b1;
                    used_next = used_reg + CW'(1);
                end
                else
                begin
                    ovf_next = ovf_reg || (carry_reg != 64'd0);
                end
            end
            S_SH_RD:
            begin
                raddr = src_m1[AW-1:0];
            end
            S_SH_WR:
            begin
                wdata   = sh_w;
                hi_next = sh_lo;
                if (sh_in_range)
                begin
                    we = 1'b1;
                    if (i_reg == IW'(0))
                    begin
                        word0_next = sh_w;
                    end
                end
                else
                begin
                    ovf_next = ovf_reg || (sh_w != 64'd0);
                end
                if (i_reg != IW'(0))
                begin
                    i_next = i_reg - IW'(1);
                end
            end
            S_SH_END:
            begin
                used_next = (top1 > IW'(WORDS)) ? CW'(WORDS) : top1[CW-1:0];
            end
            S_TRIM:
            begin
                raddr = used_reg[AW-1:0] - AW'(1);
            end
            S_TRIM_CHK:
            begin
                if (rdword == 64'd0)
                begin
                    used_next = used_reg - CW'(1);
                end
            end
            S_READ:
            begin
                raddr = AW'(idx_x);
                if (!(idx_x < used_x))
                begin
                    rv_next  = 64'd0;
                    ovf_next = 1'b1;
                end
            end
            S_READ_D:
            begin
                rv_next = rdword;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_next.word_value = (cmd_reg.func == FN_READ) ? rv_reg : word0_reg;
                    res_next.word_count = used_x[6:0];
                    res_next.is_zero    = is_zero_now;
                    res_next.overflow   = ovf_reg;
                    res_valid_next      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FINAL;
            used_reg      <= CW'(1);
            word0_reg     <= 64'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            used_reg      <= used_next;
            word0_reg     <= word0_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        nold_reg  <= nold_next;
        i_reg     <= i_next;
        e_reg     <= e_next;
        m_reg     <= m_next;
        a_reg     <= a_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        cnt_reg   <= cnt_next;
        carry_reg <= carry_next;
        hi_reg    <= hi_next;
        ovf_reg   <= ovf_next;
        rv_reg    <= rv_next;
        rd0_reg   <= (raddr == AW'(0));
        res_reg   <= res_next;
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef NO_ASSERTIONS
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != CW'(0)) && (used_x <= IW'(WORDS)))
        else $error("word count out of range");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && used_x < IW'(WORDS))
        |=> used_reg == $past(used_reg) + CW'(1))
        else $error("push did not grow the word count");

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.is_zero) |-> res_reg.word_count == 7'd1)
        else $error("zero result with count other than one");
`endif

endmodule
